/* rtl/lif_pkg.sv */
`default_nettype none

package lif_pkg;

	// operation codes carried in s_tuser; the fourth code is spurious
	typedef enum logic [1:0] {
		OP_ADD_SYN = 2'd0,
		OP_SET_BG  = 2'd1,
		OP_UPDATE  = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic [2:0] CFG_REST      = 3'd0;
	localparam logic [2:0] CFG_THRESHOLD = 3'd1;
	localparam logic [2:0] CFG_SCALE     = 3'd2;
	localparam logic [2:0] CFG_DECAY     = 3'd3;
	localparam logic [2:0] CFG_REFRACT   = 3'd4;

	// register reset values
	localparam logic signed [31:0] REST_RESET      = -32'sd64424509;
	localparam logic signed [31:0] THRESHOLD_RESET = -32'sd53687091;
	localparam logic [23:0]        SCALE_RESET     = 24'd83886;
	localparam logic [23:0]        DECAY_RESET     = 24'd16445005;
	localparam logic [15:0]        REFRACT_RESET   = 16'd50;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MLO,
		ST_MHI,
		ST_SUM,
		ST_APPLY,
		ST_FINISH
	} state_t;

	// one table entry: refractory count, background, synaptic, membrane
	typedef struct packed {
		logic [15:0]        refr;
		logic signed [31:0] bg;
		logic signed [31:0] syn;
		logic signed [31:0] mem;
	} entry_t;

	// clamp a 37-bit signed value into the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [36:0] hi;
		logic signed [36:0] lo;
		hi = 37'sh0_7FFF_FFFF;
		lo = -37'sh0_8000_0000;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/lif_neuron_exp_syn_update.sv */
`default_nettype none
// Leaky integrate-and-fire neuron table with exponential synaptic current.
// Input items arrive on the s_ stream: s_tuser is the operation (add synaptic
// weight, set background current, update one timestep), s_tdata the neuron
// index and the amount. Every item gives exactly one result item on the m_
// stream: neuron index, spike flag (m_tuser) and the membrane after the item.
// All neuron state sits in one synchronous table memory, one entry per neuron.
// One item is in work at a time. Add and set items go through table read and
// write-back. An update goes through table read, two partial products of the
// 35x24 membrane multiply, rounding sum, saturate and spike decision, and
// write-back. After reset a clearing pass writes every entry to the reset rest
// value with zero currents; no item is accepted during it, configuration
// writes are. The result sits in an output register; a stalled receiver holds
// the block in its write-back step until the result is taken, with s_tready
// low. Configuration is written through cfg_wen/cfg_index/cfg_data; the user
// is to write it only while idle, as the block itself does not enforce this.
module lif_neuron_exp_syn_update
	import lif_pkg::*;
#(
	parameter int NEURONS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // neuron[9:0], amount[41:10], zero pad
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // neuron_out[9:0], membrane_out[41:10], zero pad
	output logic [0:0]       m_tuser    // spiked[0]
);

	localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

	// configuration registers
	logic signed [31:0] rest_q;
	logic signed [31:0] thr_q;
	logic [23:0]        scale_q;
	logic [23:0]        decay_q;
	logic [15:0]        ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= REST_RESET;
			thr_q   <= THRESHOLD_RESET;
			scale_q <= SCALE_RESET;
			decay_q <= DECAY_RESET;
			ticks_q <= REFRACT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_REST:      rest_q  <= cfg_data;
				CFG_THRESHOLD: thr_q   <= cfg_data;
				CFG_SCALE:     scale_q <= cfg_data[23:0];
				CFG_DECAY:     decay_q <= cfg_data[23:0];
				CFG_REFRACT:   ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	// input field decode
	logic [9:0]         in_neuron;
	logic signed [31:0] in_amount;
	logic [16:0]        in_idx_ext;
	logic [AW+9:0]      in_idx_wide;
	logic               in_range;
	logic               s_accept;

	assign in_neuron   = s_tdata[9:0];
	assign in_amount   = s_tdata[41:10];
	assign in_idx_ext  = {7'd0, in_neuron};
	assign in_idx_wide = {{AW{1'b0}}, in_neuron};
	assign in_range    = in_idx_ext < 17'(NEURONS);
	assign s_accept    = s_tvalid && s_tready;

	// item registers
	logic [1:0]         op_q;
	logic [9:0]         idx_q;
	logic [AW-1:0]      addr_q;
	logic               inr_q;
	logic signed [31:0] amount_q;
	logic [AW-1:0]      clr_q;

	// table memory
	entry_t        tbl [NEURONS];
	entry_t        rdata_q;
	logic          rd_en;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          out_load;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= tbl[in_range ? in_idx_wide[AW-1:0] : '0];
		end
	end

	// new entry values and datapath registers
	entry_t             new_q;
	logic               spk_q;
	logic signed [34:0] drive_q;
	logic [40:0]        p_lo_q;
	logic signed [42:0] p_hi_q;
	logic signed [56:0] syn_prod_q;
	logic signed [35:0] step_q;

	// read-stage arithmetic
	logic signed [34:0] drive_d;
	logic signed [31:0] syn_add;
	entry_t             read_entry;
	assign drive_d = 35'(rest_q) - 35'(rdata_q.mem) + 35'(rdata_q.bg) + 35'(rdata_q.syn);
	assign syn_add = sat32(37'(rdata_q.syn) + 37'(amount_q));

	// entry after add or set
	always_comb begin
		read_entry = rdata_q;
		if (op_q == OP_ADD_SYN) begin
			read_entry.syn = syn_add;
		end
		if (op_q == OP_SET_BG) begin
			read_entry.bg = amount_q;
		end
	end

	// rounding sum of the partial products, floor shift by 24
	logic signed [59:0] total;
	assign total = (60'(p_hi_q) <<< 17) + 60'(p_lo_q) + 60'sd8388608;

	// apply-stage arithmetic
	logic signed [31:0] mem_sat;
	logic signed [57:0] syn_round;
	entry_t             apply_entry;
	logic               apply_spk;
	assign mem_sat   = sat32(37'(new_q.mem) + 37'(step_q));
	assign syn_round = 58'(syn_prod_q) + 58'sd8388608;

	// spike decision, refractory clamp and synaptic decay
	always_comb begin
		apply_entry     = new_q;
		apply_spk       = 1'b0;
		apply_entry.syn = syn_round[55:24];
		if (new_q.refr == 16'd0) begin
			if (mem_sat > thr_q) begin
				apply_spk        = 1'b1;
				apply_entry.mem  = rest_q;
				apply_entry.refr = ticks_q;
			end else begin
				apply_entry.mem = mem_sat;
			end
		end else begin
			apply_entry.refr = new_q.refr - 16'd1;
			apply_entry.mem  = rest_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q     <= s_tuser;
			idx_q    <= in_neuron;
			addr_q   <= in_idx_wide[AW-1:0];
			inr_q    <= in_range;
			amount_q <= in_amount;
		end
		case (state_q)
			ST_READ: begin
				drive_q <= drive_d;
				spk_q   <= 1'b0;
				new_q   <= read_entry;
			end
			ST_MLO: begin
				p_lo_q     <= drive_q[16:0] * scale_q;
				syn_prod_q <= new_q.syn * $signed({1'b0, decay_q});
			end
			ST_MHI: begin
				p_hi_q <= $signed(drive_q[34:17]) * $signed({1'b0, scale_q});
			end
			ST_SUM: begin
				step_q <= total[59:24];
			end
			ST_APPLY: begin
				new_q <= apply_entry;
				spk_q <= apply_spk;
			end
			default: ;
		endcase
	end

	// clear counter and state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == AW'(NEURONS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = ST_READ;
			ST_READ:   state_d = (inr_q && op_q == OP_UPDATE) ? ST_MLO : ST_FINISH;
			ST_MLO:    state_d = ST_MHI;
			ST_MHI:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_FINISH;
			ST_FINISH: if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = new_q;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '{refr: 16'd0, bg: 32'sd0, syn: 32'sd0, mem: REST_RESET};
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				rd_en    = s_tvalid;
			end
			ST_FINISH: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					mem_we   = inr_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {6'd0, (inr_q ? new_q.mem : 32'sd0), idx_q};
			m_tuser <= inr_q && spk_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/lif_chk.sv */
`default_nettype none

module lif_chk
	import lif_pkg::*;
#(
	parameter int NEURONS = 1024
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	logic out_of_range;
	assign out_of_range = {7'd0, m_tdata[9:0]} >= 17'(NEURONS);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// one item in work at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in work");

	// a new result only follows an item in work
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without an item in work");

	// an index beyond the table reports zero membrane and no spike
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_of_range |-> m_tdata[41:10] == 32'd0 && !m_tuser[0])
		else $error("out-of-range neuron reported state");

endmodule

bind lif_neuron_exp_syn_update lif_chk #(.NEURONS(NEURONS)) u_lif_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
